// ===== design/sca_pkg.sv =====
// Shared types and constants for the seam cost and backtrack block.
// Every other file of the block imports this package.
`default_nettype none

package sca_pkg;

  // Default map limits. The top level exposes these values as parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Widths that the item fields and configuration registers fix.
  localparam int CFG_W    = 11;
  localparam int ENERGY_W = 16;
  localparam int COST_W   = 32;
  localparam int SEAM_W   = 10;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Reset values of the size registers.
  localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = CFG_W'(1024);

  // Smallest legal map sizes.
  localparam logic [CFG_W-1:0] MIN_IMAGE_WIDTH  = CFG_W'(3);
  localparam logic [CFG_W-1:0] MIN_IMAGE_HEIGHT = CFG_W'(2);

  // Register index, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Operation codes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEAM = 1'b1;

  // Status codes of a result word.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EARLY = 1'b1;

  // Effective map size and restart request from the register file.
  typedef struct packed {
    logic             restart;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  // One result word as produced by the sequencer.
  typedef struct packed {
    logic              valid;
    logic [SEAM_W-1:0] row;
    logic [SEAM_W-1:0] column;
    logic              last;
    logic              status;
  } res_t;

endpackage

`default_nettype wire

// ===== design/sca_cfg.sv =====
// APB register file for the map size registers, with range clamping.
// Depends on sca_pkg.
`default_nettype none

module sca_cfg
  import sca_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             wr_fire;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_fire = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_fire) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  width_d  = pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_d = pwdata[CFG_W-1:0];
        default:          width_d  = width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_IMAGE_WIDTH;
      height_q <= RESET_IMAGE_HEIGHT;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp the raw values into the legal range of the map.
  always_comb begin
    cfg_o.restart = wr_fire;
    if (width_q < MIN_IMAGE_WIDTH) begin
      cfg_o.width = MIN_IMAGE_WIDTH;
    end else if (32'(width_q) > MAX_WIDTH) begin
      cfg_o.width = CFG_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q < MIN_IMAGE_HEIGHT) begin
      cfg_o.height = MIN_IMAGE_HEIGHT;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      cfg_o.height = CFG_W'(MAX_HEIGHT);
    end else begin
      cfg_o.height = height_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/sca_cost_mem.sv =====
// Cumulative cost memory: one write port and one read port, read data registered.
// Depends on sca_pkg.
`default_nettype none

module sca_cost_mem
  import sca_pkg::*;
#(
  parameter int ADDR_W = 20,
  parameter int DEPTH  = 1 << 20
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [COST_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [COST_W-1:0] rd_data_o
);

  logic [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/sca_core.sv =====
// Sequencer for cost map loading and seam backtracking over the cost memory.
// Depends on sca_pkg.
`default_nettype none

module sca_core
  import sca_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int RW        = $clog2(MAX_HEIGHT),
  localparam int ADDR_W    = RW + CW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                operation_i,
  input  wire logic [ENERGY_W-1:0] energy_i,
  output logic                     busy_o,
  input  wire cfg_t                cfg_i,
  output logic                     wr_en_o,
  output logic      [ADDR_W-1:0]   wr_addr_o,
  output logic      [COST_W-1:0]   wr_data_o,
  output logic                     rd_en_o,
  output logic      [ADDR_W-1:0]   rd_addr_o,
  input  wire logic [COST_W-1:0]   rd_data_i,
  output res_t                     res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_MIN,
    ST_WRITE
  } state_e;

  state_e              state_q, state_d;
  logic                op_q, op_d;
  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic                complete_q, complete_d;
  logic [COST_W-1:0]   best_cost_q, best_cost_d;
  logic [CW-1:0]       best_col_q, best_col_d;
  logic [RW-1:0]       trace_row_q, trace_row_d;
  logic [CW-1:0]       trace_col_q, trace_col_d;
  logic [RW-1:0]       rd_row_q, rd_row_d;
  logic [CW-1:0]       rd_col_q, rd_col_d;
  logic [COST_W-1:0]   val_c_q, val_c_d;
  logic [COST_W-1:0]   val_l_q, val_l_d;
  logic [COST_W-1:0]   min_q, min_d;

  logic                lv, rv;
  logic [CW-1:0]       rd_col_sel;
  logic [COST_W:0]     sum;
  logic [COST_W-1:0]   cost;
  logic [RW-1:0]       last_row;
  logic [31:0]         trace_row_ext;
  logic [31:0]         trace_col_ext;

  assign busy_o   = (state_q != ST_IDLE);
  assign last_row = RW'(32'(cfg_i.height) - 32'd1);

  // Neighbor validity of the column being read.
  assign lv = (rd_col_q != '0);
  assign rv = (32'(rd_col_q) + 32'd1) < 32'(cfg_i.width);

  always_comb begin
    unique case (state_q)
      ST_RD_L: rd_col_sel = lv ? rd_col_q - CW'(1) : rd_col_q;
      ST_RD_R: rd_col_sel = rv ? rd_col_q + CW'(1) : rd_col_q;
      default: rd_col_sel = rd_col_q;
    endcase
  end

  assign rd_en_o   = (state_q == ST_RD_C) || (state_q == ST_RD_L) || (state_q == ST_RD_R);
  assign rd_addr_o = {rd_row_q, rd_col_sel};

  // Saturating accumulate of the new pixel's cost.
  assign sum       = {1'b0, min_q} + (COST_W + 1)'(energy_q);
  assign cost      = sum[COST_W] ? '1 : sum[COST_W-1:0];
  assign wr_en_o   = (state_q == ST_WRITE);
  assign wr_addr_o = {row_q, col_q};
  assign wr_data_o = cost;

  assign trace_row_ext = 32'(trace_row_q);
  assign trace_col_ext = 32'(trace_col_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    energy_d    = energy_q;
    col_d       = col_q;
    row_d       = row_q;
    complete_d  = complete_q;
    best_cost_d = best_cost_q;
    best_col_d  = best_col_q;
    trace_row_d = trace_row_q;
    trace_col_d = trace_col_q;
    rd_row_d    = rd_row_q;
    rd_col_d    = rd_col_q;
    val_c_d     = val_c_q;
    val_l_d     = val_l_q;
    min_d       = min_q;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = operation_i;
          energy_d = energy_i;
          if (operation_i == OP_LOAD) begin
            if (complete_q) begin
              // A finished map is dropped and a new one begins at the origin.
              col_d       = '0;
              row_d       = '0;
              complete_d  = 1'b0;
              best_cost_d = '1;
              best_col_d  = '0;
              trace_row_d = '0;
              trace_col_d = '0;
              min_d       = '0;
              state_d     = ST_WRITE;
            end else if (row_q == '0) begin
              min_d   = '0;
              state_d = ST_WRITE;
            end else begin
              rd_row_d = row_q - RW'(1);
              rd_col_d = col_q;
              state_d  = ST_RD_C;
            end
          end else begin
            res_o.valid = 1'b1;
            if (!complete_q) begin
              res_o.status = STATUS_EARLY;
            end else begin
              res_o.status = STATUS_OK;
              res_o.row    = trace_row_ext[SEAM_W-1:0];
              res_o.column = trace_col_ext[SEAM_W-1:0];
              res_o.last   = (trace_row_q == '0);
              if (trace_row_q == '0) begin
                trace_row_d = last_row;
                trace_col_d = best_col_q;
              end else begin
                rd_row_d = trace_row_q - RW'(1);
                rd_col_d = trace_col_q;
                state_d  = ST_RD_C;
              end
            end
          end
        end
      end
      ST_RD_C: begin
        state_d = ST_RD_L;
      end
      ST_RD_L: begin
        val_c_d = rd_data_i;
        state_d = ST_RD_R;
      end
      ST_RD_R: begin
        val_l_d = rd_data_i;
        min_d   = (lv && (rd_data_i < val_c_q)) ? rd_data_i : val_c_q;
        state_d = ST_MIN;
      end
      ST_MIN: begin
        if (op_q == OP_LOAD) begin
          min_d   = (rv && (rd_data_i < min_q)) ? rd_data_i : min_q;
          state_d = ST_WRITE;
        end else begin
          // Move left when left is strictly below center and right, stay when
          // center is strictly below right, and move right otherwise.
          trace_row_d = rd_row_q;
          if (lv && (val_l_q < val_c_q)) begin
            trace_col_d = (!rv || (val_l_q < rd_data_i)) ? rd_col_q - CW'(1)
                                                         : rd_col_q + CW'(1);
          end else begin
            trace_col_d = (!rv || (val_c_q < rd_data_i)) ? rd_col_q : rd_col_q + CW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        if ((row_q == last_row) && ((col_q == '0) || (cost < best_cost_q))) begin
          best_cost_d = cost;
          best_col_d  = col_q;
        end
        if ((32'(col_q) + 32'd1) >= 32'(cfg_i.width)) begin
          col_d = '0;
          if ((32'(row_q) + 32'd1) >= 32'(cfg_i.height)) begin
            row_d       = '0;
            complete_d  = 1'b1;
            trace_row_d = last_row;
            trace_col_d = best_col_d;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write restarts the pass; writes must come only while idle, which the block does not enforce.
    if (cfg_i.restart) begin
      col_d       = '0;
      row_d       = '0;
      complete_d  = 1'b0;
      best_cost_d = '1;
      best_col_d  = '0;
      trace_row_d = '0;
      trace_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      complete_q  <= 1'b0;
      best_cost_q <= '1;
      best_col_q  <= '0;
      trace_row_q <= '0;
      trace_col_q <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      complete_q  <= complete_d;
      best_cost_q <= best_cost_d;
      best_col_q  <= best_col_d;
      trace_row_q <= trace_row_d;
      trace_col_q <= trace_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    energy_q <= energy_d;
    rd_row_q <= rd_row_d;
    rd_col_q <= rd_col_d;
    val_c_q  <= val_c_d;
    val_l_q  <= val_l_d;
    min_q    <= min_d;
  end

endmodule

`default_nettype wire

// ===== design/seam_cost_and_backtrack.sv =====
// Top level of the vertical seam cost map and backtracking block.
// Depends on sca_pkg, sca_cfg, sca_cost_mem and sca_core.
//
//   Channel    Direction  Handshake                     Payload
//   input      in         start high while busy low      operation_i, energy_i
//   result     out        done_o high for one cycle      seam_row_o, seam_column_o,
//                                                        last_o, status_o
//   config     in/out     APB write: psel&penable&pwrite paddr, pwdata, prdata
//
// A load into row zero goes straight to ST_WRITE. Any other load steps through
// ST_RD_C, ST_RD_L, ST_RD_R, ST_MIN and ST_WRITE, because it reads three cost
// entries through the single read port of the cost memory and then writes the
// new cost back. A seam step answers in the cycle after accept; when it must
// walk up a row it stays busy through ST_RD_C, ST_RD_L, ST_RD_R and ST_MIN for
// the same three reads. Reset clears all control state; the cost memory is not
// cleared, since every read reaches only entries written in the current pass.
// The receiver cannot stall, so each result word shows for one cycle only.
`default_nettype none

module seam_cost_and_backtrack
  import sca_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation_i,
  input  wire logic [ENERGY_W-1:0] energy_i,
  output logic                     done_o,
  output logic      [SEAM_W-1:0]   seam_row_o,
  output logic      [SEAM_W-1:0]   seam_column_o,
  output logic                     last_o,
  output logic                     status_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready
);

  // The cost memory is addressed by {row, column}, so each row owns a
  // power-of-two slot and no multiplier sits on the address path.
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = RW + CW;
  localparam int DEPTH  = MAX_HEIGHT * (1 << CW);

  cfg_t              cfg;
  res_t              res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [COST_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [COST_W-1:0] rd_data;

  logic              done_q;
  logic [SEAM_W-1:0] seam_row_q;
  logic [SEAM_W-1:0] seam_column_q;
  logic              last_q;
  logic              status_q;

  sca_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sca_cost_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sca_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .energy_i    (energy_i),
    .busy_o      (busy),
    .cfg_i       (cfg),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_o       (res)
  );

  // Result words are registered here; the strobe lasts exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      seam_row_q    <= res.row;
      seam_column_q <= res.column;
      last_q        <= res.last;
      status_q      <= res.status;
    end
  end

  assign done_o        = done_q;
  assign seam_row_o    = seam_row_q;
  assign seam_column_o = seam_column_q;
  assign last_o        = last_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire
